>>> src/record_log_buffer_with_half_eviction_defines.svh
// ---------------------------------------------------------------------------
// Record log buffer assertion macros
// Concurrent checks sampled on clk and disabled while rst is high.
// ---------------------------------------------------------------------------
`ifndef RECORD_LOG_BUFFER_WITH_HALF_EVICTION_DEFINES_SVH
`define RECORD_LOG_BUFFER_WITH_HALF_EVICTION_DEFINES_SVH

// Same-cycle implication.
`define RLB_ASSERT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication.
`define RLB_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

>>> src/rlb_pkg.sv
// ---------------------------------------------------------------------------
// rlb_pkg
// Shared types, command codes and sequencer states of the record log buffer.
// ---------------------------------------------------------------------------
`default_nettype none

package rlb_pkg;

  localparam int unsigned STORE_BYTES_DEF = 4096;
  localparam int unsigned PREFIX_BYTES    = 2;
  localparam int unsigned LEN_W           = 12;
  localparam int unsigned BYTE_W          = 8;

  localparam logic [1:0] CMD_APPEND = 2'd0;
  localparam logic [1:0] CMD_FIND   = 2'd1;
  localparam logic [1:0] CMD_READ   = 2'd2;
  localparam logic [1:0] CMD_NOP    = 2'd3;

  typedef struct packed {
    logic [1:0]        cmd;
    logic              first;
    logic [LEN_W-1:0]  record_length;
    logic [BYTE_W-1:0] data_byte;
    logic [LEN_W-1:0]  record_index;
    logic [LEN_W-1:0]  byte_address;
  } item_t;

  typedef struct packed {
    logic              record_found;
    logic [LEN_W-1:0]  record_offset;
    logic [LEN_W-1:0]  found_length;
    logic [LEN_W-1:0]  next_index;
    logic [BYTE_W-1:0] read_data;
    logic              status;
    logic [LEN_W-1:0]  record_count;
  } result_t;

  typedef enum logic [3:0] {
    S_IDLE,
    S_FILL,
    S_HDR_TEST,
    S_EV_TEST,
    S_EV_LO,
    S_EV_HI,
    S_EV_ADV,
    S_MOVE,
    S_MOVE_END,
    S_CHECK,
    S_HDR_HI,
    S_FD_LO,
    S_FD_HI,
    S_FD_ADV,
    S_READ
  } state_t;

endpackage

`default_nettype wire

>>> src/rlb_mem.sv
// ---------------------------------------------------------------------------
// rlb_mem
// Byte store: one write port and one read port with registered read data.
// ---------------------------------------------------------------------------
`default_nettype none

module rlb_mem #(
  parameter int unsigned DEPTH = rlb_pkg::STORE_BYTES_DEF,
  parameter int unsigned AW    = $clog2(DEPTH)
) (
  input  logic                      clk,
  input  logic                      we,
  input  logic [AW-1:0]             waddr,
  input  logic [rlb_pkg::BYTE_W-1:0] wdata,
  input  logic [AW-1:0]             raddr,
  output logic [rlb_pkg::BYTE_W-1:0] rdata
);
  import rlb_pkg::*;

  logic [BYTE_W-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

`default_nettype wire

>>> src/record_log_buffer_with_half_eviction.sv
// ---------------------------------------------------------------------------
// record_log_buffer_with_half_eviction
// Length-prefixed record log in a byte store, with front eviction of about
// half the store when an append would reach its end.
// ---------------------------------------------------------------------------
//  Channel | Ports                  | Handshake
//  --------+------------------------+---------------------------------------
//  item in | start, busy, item      | taken on a clock edge with start & !busy
//  result  | done, result           | valid for the one cycle done is high
//
//  Data byte items finish in the idle state, read-byte items wait for the
//  registered read, and find items walk the prefixes up to the clamped index
//  on a hit and answer from the idle state on a miss. Header items first
//  zero-fill the rest of an open record; an eviction walks and drops records,
//  then moves the rest of the store down byte by byte through its read port.
//  Reset is synchronous and clears the pointers and counts; the store is not
//  cleared. The receiver cannot stall: busy is high from an accepted item
//  that leaves the idle state until the cycle its result is presented.
// ---------------------------------------------------------------------------
`default_nettype none
`include "record_log_buffer_with_half_eviction_defines.svh"

module record_log_buffer_with_half_eviction #(
  parameter int unsigned STORE_BYTES = rlb_pkg::STORE_BYTES_DEF
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             start,
  input  rlb_pkg::item_t   item,
  output logic             busy,
  output logic             done,
  output rlb_pkg::result_t result
);
  import rlb_pkg::*;

  localparam int unsigned AW   = $clog2(STORE_BYTES);
  localparam int unsigned OW   = $clog2(STORE_BYTES + 1);
  localparam int unsigned RW   = $clog2(STORE_BYTES / 2 + 1);
  localparam int unsigned CW   = ((OW > LEN_W) ? OW : LEN_W) + 1;
  localparam int unsigned HALF = STORE_BYTES / 2;

  state_t            state, state_next;
  logic [OW-1:0]     append_offset, append_offset_next;
  logic [RW-1:0]     records_held, records_held_next;
  logic [LEN_W-1:0]  bytes_remaining, bytes_remaining_next;
  logic              rejecting, rejecting_next;
  logic              done_next;
  logic              wr_pend, wr_pend_next;

  logic [LEN_W-1:0]  hdr_len, hdr_len_next;
  logic [CW-1:0]     pos, pos_next;
  logic [LEN_W-1:0]  cur, cur_next;
  logic [LEN_W-1:0]  cidx, cidx_next;
  logic [RW-1:0]     dropped, dropped_next;
  logic [BYTE_W-1:0] lo, lo_next;
  logic [OW-1:0]     mv_src, mv_src_next;
  logic [OW-1:0]     mv_shift, mv_shift_next;
  logic [AW-1:0]     wr_addr, wr_addr_next;
  result_t           result_next;

  logic              mem_we;
  logic [AW-1:0]     mem_waddr;
  logic [BYTE_W-1:0] mem_wdata;
  logic [AW-1:0]     mem_raddr;
  logic [BYTE_W-1:0] mem_rdata;

  logic [LEN_W-1:0]  walk_len;
  logic [CW-1:0]     need_sum;
  logic [CW-1:0]     pos_step;
  logic [OW-1:0]     pos_clamp;
  logic [LEN_W-1:0]  find_clamp;

  rlb_mem #(
    .DEPTH (STORE_BYTES),
    .AW    (AW)
  ) u_mem (
    .clk   (clk),
    .we    (mem_we),
    .waddr (mem_waddr),
    .wdata (mem_wdata),
    .raddr (mem_raddr),
    .rdata (mem_rdata)
  );

  assign busy = (state != S_IDLE);

  // A prefix that would start on or beyond the last byte of the store reads as zero.
  assign walk_len   = ((pos + CW'(1)) >= CW'(STORE_BYTES)) ? '0
                    : {mem_rdata[LEN_W-BYTE_W-1:0], lo};
  assign need_sum   = CW'(append_offset) + CW'(hdr_len) + CW'(PREFIX_BYTES);
  assign pos_step   = pos + CW'(walk_len) + CW'(PREFIX_BYTES);
  assign pos_clamp  = (pos > CW'(append_offset)) ? append_offset : OW'(pos);
  assign find_clamp = (CW'(item.record_index) > CW'(records_held))
                    ? LEN_W'(records_held) : item.record_index;

  always_comb begin
    state_next           = state;
    append_offset_next   = append_offset;
    records_held_next    = records_held;
    bytes_remaining_next = bytes_remaining;
    rejecting_next       = rejecting;
    hdr_len_next         = hdr_len;
    pos_next             = pos;
    cur_next             = cur;
    cidx_next            = cidx;
    dropped_next         = dropped;
    lo_next              = lo;
    mv_src_next          = mv_src;
    mv_shift_next        = mv_shift;
    wr_pend_next         = 1'b0;
    wr_addr_next         = wr_addr;
    done_next            = 1'b0;
    result_next          = '0;
    // The move writes each byte in the cycle after its read.
    mem_we               = wr_pend;
    mem_waddr            = wr_addr;
    mem_wdata            = mem_rdata;
    mem_raddr            = AW'(pos);

    unique case (state)
      S_IDLE: begin
        if (start) begin
          unique case (item.cmd)
            CMD_APPEND: begin
              if (item.first) begin
                hdr_len_next = item.record_length;
                if (!rejecting && (bytes_remaining != '0)) begin
                  state_next = S_FILL;
                end else begin
                  state_next = S_HDR_TEST;
                end
              end else begin
                done_next = 1'b1;
                if (bytes_remaining != '0) begin
                  bytes_remaining_next = bytes_remaining - LEN_W'(1);
                  if (rejecting) begin
                    result_next.status = 1'b1;
                    if (bytes_remaining == LEN_W'(1)) begin
                      rejecting_next = 1'b0;
                    end
                  end else begin
                    mem_we             = (append_offset < OW'(STORE_BYTES));
                    mem_waddr          = AW'(append_offset);
                    mem_wdata          = item.data_byte;
                    append_offset_next = append_offset + OW'(1);
                  end
                end
              end
            end
            CMD_FIND: begin
              cidx_next = find_clamp;
              if (CW'(find_clamp) < CW'(records_held)) begin
                pos_next   = '0;
                cur_next   = '0;
                state_next = S_FD_LO;
              end else begin
                done_next              = 1'b1;
                result_next.next_index = find_clamp;
              end
            end
            CMD_READ: begin
              if (CW'(item.byte_address) < CW'(STORE_BYTES)) begin
                mem_raddr  = AW'(item.byte_address);
                state_next = S_READ;
              end else begin
                done_next = 1'b1;
              end
            end
            CMD_NOP: begin
              done_next = 1'b1;
            end
          endcase
        end
      end

      // Pad the open record with zero bytes before the new header.
      S_FILL: begin
        mem_we               = (append_offset < OW'(STORE_BYTES));
        mem_waddr            = AW'(append_offset);
        mem_wdata            = '0;
        append_offset_next   = append_offset + OW'(1);
        bytes_remaining_next = bytes_remaining - LEN_W'(1);
        if (bytes_remaining == LEN_W'(1)) begin
          state_next = S_HDR_TEST;
        end
      end

      S_HDR_TEST: begin
        rejecting_next       = 1'b0;
        bytes_remaining_next = '0;
        if (need_sum >= CW'(STORE_BYTES)) begin
          pos_next     = '0;
          dropped_next = '0;
          state_next   = S_EV_TEST;
        end else begin
          state_next = S_CHECK;
        end
      end

      S_EV_TEST: begin
        if ((pos < CW'(HALF)) && (dropped < records_held)) begin
          state_next = S_EV_LO;
        end else begin
          records_held_next  = records_held - dropped;
          append_offset_next = append_offset - pos_clamp;
          mv_src_next        = pos_clamp;
          mv_shift_next      = pos_clamp;
          if ((pos_clamp != '0) && (pos_clamp < OW'(STORE_BYTES))) begin
            state_next = S_MOVE;
          end else begin
            state_next = S_CHECK;
          end
        end
      end

      S_EV_LO: begin
        mem_raddr  = AW'(pos);
        state_next = S_EV_HI;
      end

      S_EV_HI: begin
        mem_raddr  = AW'(pos + CW'(1));
        lo_next    = mem_rdata;
        state_next = S_EV_ADV;
      end

      S_EV_ADV: begin
        pos_next     = pos_step;
        dropped_next = dropped + RW'(1);
        state_next   = S_EV_TEST;
      end

      // Copy the tail of the store down by the shift, one byte a cycle.
      S_MOVE: begin
        mem_raddr    = AW'(mv_src);
        wr_pend_next = 1'b1;
        wr_addr_next = AW'(mv_src - mv_shift);
        mv_src_next  = mv_src + OW'(1);
        if (mv_src == OW'(STORE_BYTES - 1)) begin
          state_next = S_MOVE_END;
        end
      end

      S_MOVE_END: begin
        state_next = S_CHECK;
      end

      S_CHECK: begin
        if (need_sum > CW'(STORE_BYTES)) begin
          rejecting_next       = (hdr_len != '0);
          bytes_remaining_next = hdr_len;
          result_next.status   = 1'b1;
          done_next            = 1'b1;
          state_next           = S_IDLE;
        end else begin
          mem_we     = 1'b1;
          mem_waddr  = AW'(append_offset);
          mem_wdata  = hdr_len[BYTE_W-1:0];
          state_next = S_HDR_HI;
        end
      end

      S_HDR_HI: begin
        mem_we               = 1'b1;
        mem_waddr            = AW'(append_offset + OW'(1));
        mem_wdata            = BYTE_W'(hdr_len >> BYTE_W);
        append_offset_next   = append_offset + OW'(PREFIX_BYTES);
        records_held_next    = records_held + RW'(1);
        bytes_remaining_next = hdr_len;
        done_next            = 1'b1;
        state_next           = S_IDLE;
      end

      S_FD_LO: begin
        mem_raddr  = AW'(pos);
        state_next = S_FD_HI;
      end

      S_FD_HI: begin
        mem_raddr  = AW'(pos + CW'(1));
        lo_next    = mem_rdata;
        state_next = S_FD_ADV;
      end

      S_FD_ADV: begin
        if ((cur == cidx) || (pos >= CW'(STORE_BYTES))) begin
          done_next                 = 1'b1;
          result_next.record_found  = 1'b1;
          result_next.found_length  = walk_len;
          result_next.record_offset = LEN_W'(pos + CW'(PREFIX_BYTES));
          result_next.next_index    = cidx + LEN_W'(1);
          state_next                = S_IDLE;
        end else begin
          pos_next   = pos_step;
          cur_next   = cur + LEN_W'(1);
          state_next = S_FD_LO;
        end
      end

      S_READ: begin
        done_next             = 1'b1;
        result_next.read_data = mem_rdata;
        state_next            = S_IDLE;
      end

      default: begin
        state_next = S_IDLE;
      end
    endcase

    result_next.record_count = LEN_W'(records_held_next);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state           <= S_IDLE;
      append_offset   <= '0;
      records_held    <= '0;
      bytes_remaining <= '0;
      rejecting       <= 1'b0;
      done            <= 1'b0;
      wr_pend         <= 1'b0;
    end else begin
      state           <= state_next;
      append_offset   <= append_offset_next;
      records_held    <= records_held_next;
      bytes_remaining <= bytes_remaining_next;
      rejecting       <= rejecting_next;
      done            <= done_next;
      wr_pend         <= wr_pend_next;
    end
  end

  always_ff @(posedge clk) begin
    hdr_len  <= hdr_len_next;
    pos      <= pos_next;
    cur      <= cur_next;
    cidx     <= cidx_next;
    dropped  <= dropped_next;
    lo       <= lo_next;
    mv_src   <= mv_src_next;
    mv_shift <= mv_shift_next;
    wr_addr  <= wr_addr_next;
    result   <= result_next;
  end

  `RLB_ASSERT(a_done_when_idle, done, !busy, "result strobe while the sequencer is busy")
  `RLB_ASSERT_NEXT(a_item_progress, start && !busy, busy || done, "accepted item left no trace")
  `RLB_ASSERT(a_count_bound, 1'b1, CW'(records_held) <= CW'(HALF), "record count too large")
  `RLB_ASSERT(a_offset_bound, 1'b1, append_offset <= OW'(STORE_BYTES), "append pointer past end")
  `RLB_ASSERT(a_move_order, wr_pend, CW'(wr_addr) < CW'(mv_src), "move write not below its source")

endmodule

`default_nettype wire
